>>> rtl/bmhq_pkg.sv
package bmhq_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_WIDTH    = 2;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

>>> rtl/bmhq_less.sv
// Shared signed comparator: lt = (lhs < rhs), two's complement.
module bmhq_less #(
   parameter int WIDTH = bmhq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic [WIDTH-1:0] lhs,
   input  logic [WIDTH-1:0] rhs,
   output logic             lt
);

   assign lt = $signed(lhs) < $signed(rhs);

endmodule

>>> rtl/bmhq_ram.sv
// Heap store: one write port, two read ports, registered read data.
module bmhq_ram #(
   parameter int DEPTH = bmhq_pkg::CAPACITY_DEFAULT,
   parameter int WIDTH = bmhq_pkg::DATA_WIDTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/binary_min_heap_queue.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_cmd, req_push_value
// rsp     | out       | rsp_valid/rsp_ready  | rsp_min_value, rsp_entry_count,
//         |           |                      | rsp_is_empty, rsp_status
//
// One item at a time. A push climbs level by level (read parent, compare)
// between its entry and exit steps. A pop first fetches the last entry
// (read, load), then descends level by level (read both children, pick
// child, compare), at most 5 levels below the root at 64 entries.
// Rejected operations and queries go straight to the result step. The pace
// is set by the one comparator and the registered read of the heap store.
// Reset (synchronous, active high) empties the heap; the store is not cleared.
// A result waiting on rsp_ready stalls only the final step; req_ready stays
// low until that result has moved into the output register.
module binary_min_heap_queue #(
   parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEFAULT,
   parameter int IW         = $clog2(CAPACITY),
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bmhq_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  logic signed [DATA_WIDTH-1:0]      req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_min_value,
   output logic [CW-1:0]                     rsp_entry_count,
   output logic                              rsp_is_empty,
   output logic [bmhq_pkg::STATUS_WIDTH-1:0] rsp_status
);

   // index arithmetic width: holds 2*pos+2 and the count
   localparam int KW = IW + 2;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_UP_RD   = 9'b000000010,
      S_UP_CMP  = 9'b000000100,
      S_LAST_RD = 9'b000001000,
      S_LAST_LD = 9'b000010000,
      S_DN_RD   = 9'b000100000,
      S_DN_KID  = 9'b001000000,
      S_DN_CMP  = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [IW-1:0]               pos_ff, pos_in;
   logic [IW-1:0]               kid_ff, kid_in;
   logic [DATA_WIDTH-1:0]       val_ff, val_in;     // value being sifted
   logic [DATA_WIDTH-1:0]       kval_ff, kval_in;   // chosen child value
   logic [DATA_WIDTH-1:0]       root_ff;            // mirror of entry 0
   bmhq_pkg::status_type        stat_ff, stat_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]       rsp_min_ff, rsp_min_in;
   logic [CW-1:0]               rsp_cnt_ff, rsp_cnt_in;
   logic                        rsp_empty_ff, rsp_empty_in;
   bmhq_pkg::status_type        rsp_stat_ff, rsp_stat_in;

   // store ports
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [DATA_WIDTH-1:0]       wr_data;
   logic [IW-1:0]               rd_addr_a;
   logic [IW-1:0]               rd_addr_b;
   logic [DATA_WIDTH-1:0]       rd_data_a;
   logic [DATA_WIDTH-1:0]       rd_data_b;

   // shared comparator
   logic [DATA_WIDTH-1:0]       cmp_lhs;
   logic [DATA_WIDTH-1:0]       cmp_rhs;
   logic                        cmp_lt;

   logic [IW-1:0]               parent_idx;
   logic [KW-1:0]               kid_left;
   logic [KW-1:0]               kid_right;
   logic [KW-1:0]               cnt_ext;
   logic                        accept;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign kid_left   = {1'b0, pos_ff, 1'b1};
   assign kid_right  = kid_left + 1'b1;
   assign cnt_ext    = KW'(cnt_ff);

   bmhq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH),
      .AW    (IW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   bmhq_less #(
      .WIDTH (DATA_WIDTH)
   ) u_less (
      .lhs (cmp_lhs),
      .rhs (cmp_rhs),
      .lt  (cmp_lt)
   );

   // comparator operand select
   always_comb begin
      cmp_lhs = val_ff;
      cmp_rhs = rd_data_a;
      unique case (state_ff)
         S_DN_KID: begin
            cmp_lhs = rd_data_b;
            cmp_rhs = rd_data_a;
         end
         S_DN_CMP: begin
            cmp_lhs = kval_ff;
            cmp_rhs = val_ff;
         end
         default: begin
            cmp_lhs = val_ff;
            cmp_rhs = rd_data_a;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      kid_in       = kid_ff;
      val_in       = val_ff;
      kval_in      = kval_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;
      rd_addr_a    = kid_left[IW-1:0];
      rd_addr_b    = kid_right[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               stat_in = bmhq_pkg::STATUS_OK;
               unique case (req_cmd)
                  bmhq_pkg::CMD_PUSH: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        stat_in  = bmhq_pkg::STATUS_FULL;
                        state_in = S_DONE;
                     end else begin
                        val_in   = req_push_value;
                        pos_in   = cnt_ff[IW-1:0];
                        cnt_in   = cnt_ff + 1'b1;
                        state_in = S_UP_RD;
                     end
                  end
                  bmhq_pkg::CMD_POP: begin
                     if (cnt_ff == '0) begin
                        stat_in  = bmhq_pkg::STATUS_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        cnt_in   = cnt_ff - 1'b1;
                        pos_in   = '0;
                        state_in = S_LAST_RD;
                     end
                  end
                  default: begin
                     // query, and the unused code: report only
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_UP_RD: begin
            rd_addr_a = parent_idx;
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               // parent moves down into the hole
               wr_data  = rd_data_a;
               pos_in   = parent_idx;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LAST_RD: begin
            rd_addr_a = cnt_ff[IW-1:0];
            state_in  = S_LAST_LD;
         end
         S_LAST_LD: begin
            val_in   = rd_data_a;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (kid_left >= cnt_ext) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_KID;
            end
         end
         S_DN_KID: begin
            // right child only when present and strictly less
            if ((kid_right < cnt_ext) && cmp_lt) begin
               kval_in = rd_data_b;
               kid_in  = kid_right[IW-1:0];
            end else begin
               kval_in = rd_data_a;
               kid_in  = kid_left[IW-1:0];
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = kval_ff;
               pos_in   = kid_ff;
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = (cnt_ff == '0) ? '0 : root_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_empty_in = (cnt_ff == '0);
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      kid_ff       <= kid_in;
      val_ff       <= val_in;
      kval_ff      <= kval_in;
      stat_ff      <= stat_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_stat_ff  <= rsp_stat_in;
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_stat_ff;

endmodule

>>> rtl/bmhq_checker.sv
module bmhq_checker #(
   parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEFAULT,
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [DATA_WIDTH-1:0]             rsp_min_value,
   input logic [CW-1:0]                     rsp_entry_count,
   input logic                              rsp_is_empty,
   input logic [bmhq_pkg::STATUS_WIDTH-1:0] rsp_status
);

   // empty flag tracks the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with count");

   // empty heap reports zero minimum
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_min_value == '0))
      else $error("nonzero minimum on empty heap");

   // rejected push only at full, rejected pop only at empty
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_status != bmhq_pkg::STATUS_FULL) || (rsp_entry_count == CW'(CAPACITY))) &&
         ((rsp_status != bmhq_pkg::STATUS_EMPTY) || (rsp_entry_count == '0)))
      else $error("reject status with wrong count");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_min_value) && $stable(rsp_entry_count) &&
          $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind binary_min_heap_queue bmhq_checker #(
   .CAPACITY   (CAPACITY),
   .DATA_WIDTH (DATA_WIDTH),
   .CW         (CW)
) u_bmhq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_min_value   (rsp_min_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty),
   .rsp_status      (rsp_status)
);

>>> tb/heap_checker.sv
`timescale 1ns / 1ps

module heap_checker #(
   parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = bmhq_pkg::DATA_WIDTH_DEFAULT,
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [bmhq_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  logic signed [DATA_WIDTH-1:0]      req_push_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [DATA_WIDTH-1:0]      rsp_min_value,
   input  logic [CW-1:0]                     rsp_entry_count,
   input  logic                              rsp_is_empty,
   input  logic [bmhq_pkg::STATUS_WIDTH-1:0] rsp_status,
   output int                                fail_count,
   output int                                pending_count,
   output int                                replies_checked,
   output int                                full_rejects,
   output int                                empty_rejects
);

   localparam int CMD_WIDTH    = bmhq_pkg::CMD_WIDTH;
   localparam int STATUS_WIDTH = bmhq_pkg::STATUS_WIDTH;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]         op;
      logic signed [DATA_WIDTH-1:0] min_value;
      logic [CW-1:0]                entry_count;
      logic                         is_empty;
      logic [STATUS_WIDTH-1:0]      status;
   } heap_reply_type;

   // shadow heap
   logic signed [DATA_WIDTH-1:0] heap_mem [CAPACITY];
   int                           heap_size;
   heap_reply_type               expected_replies [$];

   initial begin
      fail_count      = 0;
      pending_count   = 0;
      replies_checked = 0;
      full_rejects    = 0;
      empty_rejects   = 0;
      heap_size       = 0;
   end

   function automatic void swap_slots(int a, int b);
      logic signed [DATA_WIDTH-1:0] t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
   endfunction

   function automatic heap_reply_type heap_apply(logic [CMD_WIDTH-1:0] op,
                                                 logic signed [DATA_WIDTH-1:0] value);
      heap_reply_type r;
      int             pos;
      int             kid;
      r.op     = op;
      r.status = bmhq_pkg::STATUS_OK;
      case (bmhq_pkg::cmd_type'(op))
         bmhq_pkg::CMD_PUSH: begin
            if (heap_size >= CAPACITY) begin
               r.status = bmhq_pkg::STATUS_FULL;
            end else begin
               heap_mem[heap_size] = value;
               pos = heap_size;
               heap_size++;
               // climb while the parent is strictly greater
               while (pos > 0 && heap_mem[pos] < heap_mem[(pos - 1) / 2]) begin
                  swap_slots(pos, (pos - 1) / 2);
                  pos = (pos - 1) / 2;
               end
            end
         end
         bmhq_pkg::CMD_POP: begin
            if (heap_size == 0) begin
               r.status = bmhq_pkg::STATUS_EMPTY;
            end else begin
               heap_size--;
               heap_mem[0] = heap_mem[heap_size];
               pos = 0;
               kid = 1;
               while (kid < heap_size) begin
                  // right child only when strictly less
                  if (kid + 1 < heap_size && heap_mem[kid + 1] < heap_mem[kid])
                     kid++;
                  if (heap_mem[kid] < heap_mem[pos]) begin
                     swap_slots(kid, pos);
                     pos = kid;
                     kid = 2 * pos + 1;
                  end else begin
                     kid = heap_size;
                  end
               end
            end
         end
         default: ;
      endcase
      r.min_value   = (heap_size > 0) ? heap_mem[0] : '0;
      r.entry_count = CW'(heap_size);
      r.is_empty    = (heap_size == 0);
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      heap_reply_type want;
      if (reset) begin
         heap_size = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with no item outstanding: min=%0d count=%0d",
                           $realtime, rsp_min_value, rsp_entry_count);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_min_value !== want.min_value || rsp_entry_count !== want.entry_count ||
                   rsp_is_empty !== want.is_empty || rsp_status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch cmd=%0d exp min=%0d cnt=%0d empty=%0b st=%0d",
                              $realtime, want.op, want.min_value, want.entry_count,
                              want.is_empty, want.status);
                     $display("%0t:    got min=%0d cnt=%0d empty=%0b st=%0d",
                              $realtime, rsp_min_value, rsp_entry_count,
                              rsp_is_empty, rsp_status);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = heap_apply(req_cmd, req_push_value);
            if (want.status == bmhq_pkg::STATUS_FULL)  full_rejects++;
            if (want.status == bmhq_pkg::STATUS_EMPTY) empty_rejects++;
            expected_replies.push_back(want);
         end
      end
      pending_count = expected_replies.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY     = 64;
   localparam int DATA_WIDTH   = 32;
   localparam int CW           = $clog2(CAPACITY + 1);
   localparam int CMD_WIDTH    = bmhq_pkg::CMD_WIDTH;
   localparam int STATUS_WIDTH = bmhq_pkg::STATUS_WIDTH;

   // code 3 is not in the command enum; the block treats it as a query
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   localparam int TOTAL_ITEMS  = 1750;
   localparam int QUIET_ITEMS  = 150;   // tail of the run with no idling
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 40;    // idle time after the last result

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [CMD_WIDTH-1:0]         req_cmd = bmhq_pkg::CMD_QUERY;
   logic signed [DATA_WIDTH-1:0] req_push_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0] rsp_min_value;
   logic [CW-1:0]                rsp_entry_count;
   logic                         rsp_is_empty;
   logic [STATUS_WIDTH-1:0]      rsp_status;

   int fail_count;
   int pending_count;
   int replies_checked;
   int full_rejects;
   int empty_rejects;

   int sent_count = 0;   // items accepted so far
   int fill_level = 0;   // rough occupancy, only to steer the stimulus
   bit quiet      = 1'b0;
   bit hold_done  = 1'b0;
   int stall_cycles = 0;

   binary_min_heap_queue #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_min_value   (rsp_min_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   heap_checker #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_min_value   (rsp_min_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .replies_checked (replies_checked),
      .full_rejects    (full_rejects),
      .empty_rejects   (empty_rejects)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Half full-range words, with the two extremes and a narrow band
   // around zero so that equal keys meet in the heap often.
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Offer one item and hold it until accepted. All driving happens at the
   // falling edge; acceptance is seen at the rising edge. An optional idle
   // burst comes first, so valid drops and rises on different edges.
   task automatic send_item(input logic [CMD_WIDTH-1:0] op,
                            input logic signed [DATA_WIDTH-1:0] value);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid      <= 1'b0;
         req_cmd        <= CMD_WIDTH'($urandom);
         req_push_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= op;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (op == bmhq_pkg::CMD_PUSH && fill_level < CAPACITY) fill_level++;
      if (op == bmhq_pkg::CMD_POP && fill_level > 0)         fill_level--;
   endtask

   task automatic send_push(input logic signed [DATA_WIDTH-1:0] value);
      send_item(bmhq_pkg::CMD_PUSH, value);
   endtask

   // push_value is don't-care for these, so give it noise
   task automatic send_other(input logic [CMD_WIDTH-1:0] op);
      send_item(op, $urandom);
   endtask

   // Receiver: short random stalls, one long hold-off early on that backs
   // the block up while the sender keeps offering, none in the quiet tail.
   initial begin : receiver
      int n;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= 60) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = $urandom_range(0, 20);
            rsp_ready <= 1'b1;
            repeat (n) @(negedge clock);
         end
      end
   end

   // Watchdog: any cycle with a handshake on either channel resets it.
   initial begin : watchdog
      wait (reset == 1'b0);
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_count);
      $display("** binary_min_heap_queue: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int n;
      int r;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: empty-heap queries and pop reject, unused code on empty
      send_other(bmhq_pkg::CMD_QUERY);
      send_other(bmhq_pkg::CMD_POP);
      send_other(CMD_UNUSED);
      // extremes and neighbors of zero
      send_push(32'sd0);
      send_push(32'sh7fff_ffff);
      send_push(32'sh8000_0000);
      send_push(-32'sd1);
      send_push(32'sd1);
      send_push(32'sh8000_0000);
      send_other(bmhq_pkg::CMD_QUERY);
      send_other(CMD_UNUSED);
      // drain to empty, then one pop too many
      repeat (6) send_other(bmhq_pkg::CMD_POP);
      send_other(bmhq_pkg::CMD_POP);
      // equal keys
      repeat (3) send_push(32'sd5);
      repeat (3) send_other(bmhq_pkg::CMD_POP);

      // random segments: fill past full, drain past empty, or mixed traffic
      while (sent_count < TOTAL_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r <= 2) begin
            n = CAPACITY - fill_level + $urandom_range(0, 3);
            repeat (n) send_push(pick_value());
         end else if (r <= 5) begin
            n = fill_level + $urandom_range(0, 3);
            repeat (n) send_other(bmhq_pkg::CMD_POP);
         end else begin
            repeat (24) begin
               n = $urandom_range(0, 19);
               if (n < 10)      send_push(pick_value());
               else if (n < 17) send_other(bmhq_pkg::CMD_POP);
               else if (n < 19) send_other(bmhq_pkg::CMD_QUERY);
               else             send_other(CMD_UNUSED);
            end
         end
         if (sent_count >= TOTAL_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      // watchdog covers a block that never answers
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d items, %0d results checked, %0d pushes refused when full,",
               sent_count, replies_checked, full_rejects);
      $display("%0d pops refused when empty, %0d mismatches, %0d results left over",
               empty_rejects, fail_count, pending_count);
      if (fail_count == 0 && pending_count == 0)
         $display("** binary_min_heap_queue: PASSED **");
      else
         $display("** binary_min_heap_queue: FAILED **");
      $finish;
   end

endmodule
